/* sv/bpa_pkg.sv */
// Package with the constants, types and helper functions of the bitmap page allocator.
package bpa_pkg;

    // Sizing of the managed memory.
    localparam int PAGE_BYTES         = 4096;
    localparam int NUM_PAGES          = 32768;
    localparam int INITIAL_FREE_PAGES = 4096;

    // Field widths of the channels and the configuration register.
    localparam int CFG_W  = 16;
    localparam int FADR_W = 32;
    localparam int ADDR_W = 27;

    // Derived widths: page index, count (which can reach NUM_PAGES) and map words.
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int CNT_W      = PAGE_W + 1;
    localparam int WORD_BITS  = 32;
    localparam int WORD_W     = $clog2(WORD_BITS);
    localparam int ROWS       = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int FREE_END   = (INITIAL_FREE_PAGES < NUM_PAGES) ? INITIAL_FREE_PAGES
                                                                 : NUM_PAGES;

    // Reset value of the page count register.
    localparam logic [CFG_W-1:0] PAGES_IN_USE_RESET = CFG_W'(32768);

    typedef logic [WORD_BITS-1:0] map_word_t;

    // Request to the word scanner: which word, which pass and the range limits.
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic              wrapped;
        logic [PAGE_W-1:0] start;
        logic [PAGE_W-1:0] last;
    } scan_req_t;

    // Answer of the word scanner.
    typedef struct packed {
        logic              found;
        logic [WORD_W-1:0] bit_idx;
    } scan_res_t;

    // Contents of one map row after reset: pages 1 up to FREE_END-1 are free.
    function automatic map_word_t init_word(input logic [ROW_W-1:0] row);
        map_word_t w;
        int        p;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            p    = int'(row) * WORD_BITS + j;
            w[j] = !((p >= 1) && (p < FREE_END));
        end
        return w;
    endfunction

endpackage

/* sv/bpa_if.sv */
// Handshake interfaces for the request and response channels of the page allocator.
interface bpa_req_if;
    import bpa_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [FADR_W-1:0] free_address;

    modport source (output valid, output kind, output free_address, input ready);
    modport sink   (input valid, input kind, input free_address, output ready);
endinterface

interface bpa_rsp_if;
    import bpa_pkg::*;
    logic              valid;
    logic              ready;
    logic              ok;
    logic [ADDR_W-1:0] page_address;

    modport source (output valid, output ok, output page_address, input ready);
    modport sink   (input valid, input ok, input page_address, output ready);
endinterface

/* sv/bpa_word_scan.sv */
// Shared scan unit: masks one map word to the search range and finds its lowest free page.
module bpa_word_scan (
    input  bpa_pkg::map_word_t word,
    input  bpa_pkg::scan_req_t req,
    output bpa_pkg::scan_res_t res
);
    import bpa_pkg::*;

    localparam map_word_t ALL_ONES = '1;

    logic [ROW_W-1:0]  start_row;
    logic [ROW_W-1:0]  last_row;
    logic [WORD_W-1:0] start_bit;
    logic [WORD_W-1:0] last_bit;
    map_word_t         lo_mask;
    map_word_t         hi_mask;
    map_word_t         free_bits;
    logic [WORD_W-1:0] idx;

    assign start_row = ROW_W'(req.start >> WORD_W);
    assign last_row  = ROW_W'(req.last >> WORD_W);
    assign start_bit = req.start[WORD_W-1:0];
    assign last_bit  = req.last[WORD_W-1:0];

    // Lower edge: the first pass starts at the hint, the wrapped pass stops below it.
    always_comb
    begin
        lo_mask = ALL_ONES;
        if (req.row == start_row)
        begin
            if (req.wrapped)
                lo_mask = ~(ALL_ONES << start_bit);
            else
                lo_mask = ALL_ONES << start_bit;
        end
    end

    // Upper edge: no page at or beyond the managed count.
    always_comb
    begin
        hi_mask = ALL_ONES;
        if (req.row == last_row)
            hi_mask = ALL_ONES >> (WORD_W'(WORD_BITS - 1) - last_bit);
    end

    assign free_bits = ~word & lo_mask & hi_mask;

    // Lowest set bit of the free pattern.
    always_comb
    begin
        idx = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (free_bits[j])
                idx = WORD_W'(j);
        end
    end

    assign res.found   = |free_bits;
    assign res.bit_idx = idx;

endmodule

/* sv/bitmap_page_allocator.sv */
// Bitmap page allocator: one used bit per page, next-fit allocation and page release.
//
// Requests arrive on the req channel (kind 0 = allocate, kind 1 = free the page holding
// free_address); each request gives exactly one response beat on rsp (ok, page_address).
// A beat moves on any rising edge where valid and ready are both high.
// The user must write the page count register through cfg_wr_en / cfg_wr_data only while
// the block is idle; the block does not enforce this. The used map lives in a single-port-write
// memory of 32-bit rows; one scan unit inspects one row at a time (read, then mask and
// find-first). An allocate visits rows from the hint's row on, wrapping round to row 0,
// until a free page turns up or the whole range is swept; a free reads and rewrites one
// row; an out-of-range free or an allocate with a page count of zero touches no row. The
// block handles one request at a time and is ready again as soon as the result sits in the
// output register. After reset a clearing pass writes the initial map, one row a cycle, over
// all 1024 rows; req.ready stays low until it ends. Configuration writes are taken throughout.
// When the receiver stalls, the result waits in the output register; a next request is
// still taken and worked on, and its result waits until the output register has emptied.
module bitmap_page_allocator (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [bpa_pkg::CFG_W-1:0] cfg_wr_data,
    bpa_req_if.sink                   req,
    bpa_rsp_if.source                 rsp
);
    import bpa_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_RD,
        ST_ALLOC_CHK,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_DONE
    } state_t;

    // Used map storage.
    map_word_t        map_mem [ROWS];
    map_word_t        rd_data_reg;
    logic             mem_we;
    logic [ROW_W-1:0] mem_waddr;
    map_word_t        mem_wdata;
    logic             mem_re;
    logic [ROW_W-1:0] mem_raddr;

    state_t            state_reg,     state_next;
    logic [ROW_W-1:0]  clr_row_reg,   clr_row_next;
    logic [CFG_W-1:0]  pages_reg;
    logic [CNT_W-1:0]  hint_reg,      hint_next;
    logic [PAGE_W-1:0] start_reg,     start_next;
    logic [PAGE_W-1:0] last_reg,      last_next;
    logic [ROW_W-1:0]  row_reg,       row_next;
    logic              wrapped_reg,   wrapped_next;
    logic [PAGE_W-1:0] page_reg,      page_next;
    logic              res_ok_reg,    res_ok_next;
    logic              res_alloc_reg, res_alloc_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              rsp_ok_reg,    rsp_ok_next;
    logic [ADDR_W-1:0] rsp_addr_reg,  rsp_addr_next;

    logic [CNT_W-1:0]  limit;
    logic [PAGE_W-1:0] start_page;
    logic [FADR_W-1:0] free_page_full;
    logic [PAGE_W-1:0] found_page;
    logic [ROW_W-1:0]  start_row;
    logic [ROW_W-1:0]  last_row;
    map_word_t         bit_onehot;
    scan_req_t         scan_req;
    scan_res_t         scan_res;

    // Managed page count, clamped to the size of the map.
    assign limit = ({1'b0, pages_reg} > (CFG_W + 1)'(NUM_PAGES)) ? CNT_W'(NUM_PAGES)
                                                                  : CNT_W'(pages_reg);

    // Next-fit start: the hint when it lies inside the managed range, otherwise page 0.
    assign start_page     = (hint_reg < limit) ? hint_reg[PAGE_W-1:0] : '0;
    assign free_page_full = req.free_address >> PAGE_SHIFT;
    assign start_row      = ROW_W'(start_reg >> WORD_W);
    assign last_row       = ROW_W'(last_reg >> WORD_W);

    // Shared scan unit over the row just read.
    assign scan_req.row     = row_reg;
    assign scan_req.wrapped = wrapped_reg;
    assign scan_req.start   = start_reg;
    assign scan_req.last    = last_reg;

    bpa_word_scan u_scan (
        .word (rd_data_reg),
        .req  (scan_req),
        .res  (scan_res)
    );

    assign found_page = {row_reg, scan_res.bit_idx};
    assign bit_onehot = map_word_t'(1) << (state_reg == ST_ALLOC_CHK ? scan_res.bit_idx
                                                                       : page_reg[WORD_W-1:0]);

    // Memory access control.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = row_reg;
        mem_wdata = rd_data_reg;
        mem_re    = 1'b0;
        mem_raddr = row_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_row_reg;
                mem_wdata = init_word(clr_row_reg);
            end
            ST_ALLOC_RD:
            begin
                mem_re = 1'b1;
            end
            ST_ALLOC_CHK:
            begin
                mem_we    = scan_res.found;
                mem_wdata = rd_data_reg | bit_onehot;
            end
            ST_FREE_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = ROW_W'(page_reg >> WORD_W);
            end
            ST_FREE_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ROW_W'(page_reg >> WORD_W);
                mem_wdata = rd_data_reg & ~bit_onehot;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Map memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= map_mem[mem_raddr];
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        clr_row_next   = clr_row_reg;
        hint_next      = hint_reg;
        start_next     = start_reg;
        last_next      = last_reg;
        row_next       = row_reg;
        wrapped_next   = wrapped_reg;
        page_next      = page_reg;
        res_ok_next    = res_ok_reg;
        res_alloc_next = res_alloc_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_ok_next    = rsp_ok_reg;
        rsp_addr_next  = rsp_addr_reg;

        // The output register empties when its beat is taken.
        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == ROW_W'(ROWS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    res_ok_next    = 1'b0;
                    res_alloc_next = ~req.kind;
                    if (!req.kind)
                    begin
                        start_next   = start_page;
                        last_next    = PAGE_W'(limit - 1'b1);
                        row_next     = ROW_W'(start_page >> WORD_W);
                        wrapped_next = 1'b0;
                        state_next   = (limit == '0) ? ST_DONE : ST_ALLOC_RD;
                    end
                    else if (free_page_full < FADR_W'(limit))
                    begin
                        page_next  = free_page_full[PAGE_W-1:0];
                        state_next = ST_FREE_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ALLOC_RD:
            begin
                state_next = ST_ALLOC_CHK;
            end
            ST_ALLOC_CHK:
            begin
                if (scan_res.found)
                begin
                    page_next   = found_page;
                    hint_next   = CNT_W'(found_page) + 1'b1;
                    res_ok_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (!wrapped_reg && (row_reg == last_row))
                begin
                    // End of the first pass: wrap to page 0 unless the pass began there.
                    if (start_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        wrapped_next = 1'b1;
                        row_next     = '0;
                        state_next   = ST_ALLOC_RD;
                    end
                end
                else if (wrapped_reg && (row_reg == start_row))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_ALLOC_RD;
                end
            end
            ST_FREE_RD:
            begin
                state_next = ST_FREE_WR;
            end
            ST_FREE_WR:
            begin
                if (CNT_W'(page_reg) < hint_reg)
                    hint_next = CNT_W'(page_reg);
                res_ok_next = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ok_next    = res_ok_reg;
                    rsp_addr_next  = (res_ok_reg && res_alloc_reg)
                                   ? ADDR_W'((ADDR_W + PAGE_W)'(page_reg) << PAGE_SHIFT)
                                   : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, working registers and the registered response.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            pages_reg     <= PAGES_IN_USE_RESET;
            hint_reg      <= '0;
            start_reg     <= '0;
            last_reg      <= '0;
            row_reg       <= '0;
            wrapped_reg   <= 1'b0;
            page_reg      <= '0;
            res_ok_reg    <= 1'b0;
            res_alloc_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_ok_reg    <= 1'b0;
            rsp_addr_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            if (cfg_wr_en)
                pages_reg <= cfg_wr_data;
            hint_reg      <= hint_next;
            start_reg     <= start_next;
            last_reg      <= last_next;
            row_reg       <= row_next;
            wrapped_reg   <= wrapped_next;
            page_reg      <= page_next;
            res_ok_reg    <= res_ok_next;
            res_alloc_reg <= res_alloc_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_ok_reg    <= rsp_ok_next;
            rsp_addr_reg  <= rsp_addr_next;
        end
    end

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.ok           = rsp_ok_reg;
    assign rsp.page_address = rsp_addr_reg;

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the bitmap page allocator: directed table, then random phases.
module testbench;
    import bpa_pkg::*;

    // Request kinds carried on the request channel.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 10;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_BURST       = 17;
    localparam int NUM_PHASES      = 12;
    localparam int QUIET_PHASES    = 2;
    localparam int BIG_PHASE_BEATS = 40;
    localparam int PHASE_BEATS     = 100;

    typedef enum logic [1:0] {STEP_ALLOC, STEP_FREE, STEP_WRITE_COUNT} step_t;

    typedef struct packed {
        step_t             step;
        logic [31:0]       value;
        logic              typed;
        logic              ok;
        logic [ADDR_W-1:0] page_address;
    } dir_row_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] page_address;
    } page_result_t;

    // Directed rows: allocation from reset, unaligned and out-of-range frees, the clamped
    // page count, a zero page count and a hint left above a lowered page count.
    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{STEP_ALLOC,       32'h0000_0000, 1'b1, 1'b1, 27'h000_1000},
        '{STEP_ALLOC,       32'h0000_0000, 1'b1, 1'b1, 27'h000_2000},
        '{STEP_FREE,        32'h0000_1ABC, 1'b1, 1'b1, 27'h000_0000},
        '{STEP_ALLOC,       32'h0000_0000, 1'b1, 1'b1, 27'h000_1000},
        '{STEP_FREE,        32'h0000_0000, 1'b1, 1'b1, 27'h000_0000},
        '{STEP_ALLOC,       32'h0000_0000, 1'b1, 1'b1, 27'h000_0000},
        '{STEP_FREE,        32'hFFFF_FFFF, 1'b1, 1'b0, 27'h000_0000},
        '{STEP_FREE,        32'h0800_0000, 1'b1, 1'b0, 27'h000_0000},
        '{STEP_FREE,        32'h07FF_FFFF, 1'b1, 1'b1, 27'h000_0000},
        '{STEP_FREE,        32'h0000_5000, 1'b1, 1'b1, 27'h000_0000},
        '{STEP_WRITE_COUNT, 32'h0000_FFFF, 1'b0, 1'b0, 27'h000_0000},
        '{STEP_FREE,        32'h0800_0000, 1'b1, 1'b0, 27'h000_0000},
        '{STEP_ALLOC,       32'h0000_0000, 1'b0, 1'b0, 27'h000_0000},
        '{STEP_WRITE_COUNT, 32'h0000_0000, 1'b0, 1'b0, 27'h000_0000},
        '{STEP_ALLOC,       32'h0000_0000, 1'b1, 1'b0, 27'h000_0000},
        '{STEP_FREE,        32'h0000_0000, 1'b1, 1'b0, 27'h000_0000},
        '{STEP_WRITE_COUNT, 32'h0000_0003, 1'b0, 1'b0, 27'h000_0000},
        '{STEP_ALLOC,       32'h0000_0000, 1'b0, 1'b0, 27'h000_0000},
        '{STEP_FREE,        32'h0000_2FFF, 1'b1, 1'b1, 27'h000_0000},
        '{STEP_ALLOC,       32'h0000_0000, 1'b0, 1'b0, 27'h000_0000},
        '{STEP_WRITE_COUNT, 32'h0000_8000, 1'b0, 1'b0, 27'h000_0000},
        '{STEP_ALLOC,       32'h0000_0000, 1'b0, 1'b0, 27'h000_0000},
        '{STEP_FREE,        32'hAAAA_5555, 1'b1, 1'b0, 27'h000_0000},
        '{STEP_FREE,        32'h5555_AAAA, 1'b1, 1'b0, 27'h000_0000}
    };

    // Page counts of the random phases; the big ones get fewer beats.
    localparam logic [CFG_W-1:0] PHASE_COUNTS [NUM_PHASES] = '{
        16'd64, 16'd40, 16'd65535, 16'd1, 16'd128, 16'd0,
        16'd33, 16'd300, 16'd32768, 16'd2, 16'd96, 16'd64
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    bpa_req_if req_bus ();
    bpa_rsp_if rsp_bus ();

    bitmap_page_allocator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_bus),
        .rsp         (rsp_bus)
    );

    // Mirror of the allocator state and the results still owed by the block.
    bit               page_used [NUM_PAGES];
    int unsigned      next_fit_hint;
    logic [CFG_W-1:0] page_count;
    page_result_t     owed_results [$];
    int unsigned      mismatch_count;
    int unsigned      gap_pct;
    int unsigned      stall_pct;

    // Applies one request to the mirror and returns the result the block must give.
    function automatic page_result_t serve_page_request(input logic kind,
                                                        input logic [FADR_W-1:0] addr);
        page_result_t res;
        int unsigned  limit;
        int unsigned  wrap_end;
        int unsigned  page;
        int unsigned  p;
        bit           found;
        res   = '0;
        limit = (page_count > NUM_PAGES) ? NUM_PAGES : page_count;
        found = 1'b0;
        page  = 0;
        if (kind == KIND_ALLOC)
        begin
            // Next fit: from the hint to the end, then wrap round from page zero.
            wrap_end = (next_fit_hint < limit) ? next_fit_hint : limit;
            for (p = next_fit_hint; p < limit && !found; p++)
            begin
                if (!page_used[p])
                begin
                    found = 1'b1;
                    page  = p;
                end
            end
            for (p = 0; p < wrap_end && !found; p++)
            begin
                if (!page_used[p])
                begin
                    found = 1'b1;
                    page  = p;
                end
            end
            if (found)
            begin
                page_used[page]  = 1'b1;
                next_fit_hint    = page + 1;
                res.ok           = 1'b1;
                res.page_address = ADDR_W'(page << PAGE_SHIFT);
            end
        end
        else
        begin
            page = addr >> PAGE_SHIFT;
            if (page < limit)
            begin
                page_used[page] = 1'b0;
                if (page < next_fit_hint)
                    next_fit_hint = page;
                res.ok = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    endtask

    // Offers one request beat, with an optional idle burst first, and records its result.
    task automatic send_request(input logic kind, input logic [FADR_W-1:0] addr,
                                input bit typed, input page_result_t typed_result);
        page_result_t predicted;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.kind         <= kind;
        req_bus.free_address <= addr;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        predicted = serve_page_request(kind, addr);
        owed_results.push_back(typed ? typed_result : predicted);
    endtask

    // Writes the page count once every owed result has come back.
    task automatic write_page_count(input logic [CFG_W-1:0] value);
        req_bus.valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        page_count  = value;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("Verification failed");
        $finish;
    end

    // Response side: ready drops in random stall bursts while stall_pct is non-zero.
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
        end
    end

    // Each response beat is checked against the oldest owed result.
    always @(posedge clk)
    begin
        page_result_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (owed_results.size() == 0)
                report_mismatch("beat with no result owed, page_address",
                                rsp_bus.page_address, 0);
            else
            begin
                want = owed_results.pop_front();
                if (rsp_bus.ok !== want.ok)
                    report_mismatch("ok", rsp_bus.ok, want.ok);
                if (rsp_bus.page_address !== want.page_address)
                    report_mismatch("page_address", rsp_bus.page_address, want.page_address);
            end
        end
    end

    initial
    begin
        dir_row_t         row;
        int unsigned      ph;
        int unsigned      beats;
        int unsigned      alloc_pct;
        int unsigned      limit;
        logic [31:0]      addr;
        bit               quiet;

        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        req_bus.valid        = 1'b0;
        req_bus.kind         = KIND_ALLOC;
        req_bus.free_address = '0;
        gap_pct              = 0;
        stall_pct            = 0;
        mismatch_count       = 0;

        // Mirror state after reset: pages 1 up to the initial free count are free.
        for (int p = 0; p < NUM_PAGES; p++)
            page_used[p] = !((p >= 1) && (p < FREE_END));
        next_fit_hint = 0;
        page_count    = PAGES_IN_USE_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, with no idling on either side.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIR_TABLE[i];
            case (row.step)
                STEP_WRITE_COUNT: write_page_count(row.value[CFG_W-1:0]);
                STEP_ALLOC:       send_request(KIND_ALLOC, $urandom(), row.typed,
                                               page_result_t'{row.ok, row.page_address});
                default:          send_request(KIND_FREE, row.value, row.typed,
                                               page_result_t'{row.ok, row.page_address});
            endcase
        end

        // Random phases: each with its own page count and mix of kinds, and idling but in the quiet last ones.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_page_count(PHASE_COUNTS[ph]);
            quiet     = (ph >= NUM_PHASES - QUIET_PHASES);
            gap_pct   = quiet ? 0 : 10 * $urandom_range(0, 3);
            stall_pct = quiet ? 0 : 2 * $urandom_range(0, 4);
            alloc_pct = 30 + 20 * $urandom_range(0, 2);
            limit     = (page_count > NUM_PAGES) ? NUM_PAGES : page_count;
            beats     = (page_count >= FREE_END) ? BIG_PHASE_BEATS : PHASE_BEATS;
            repeat (beats)
            begin
                if ($urandom_range(1, 100) <= alloc_pct)
                    send_request(KIND_ALLOC, $urandom(), 1'b0, '0);
                else
                begin
                    // Mostly pages near the managed range, now and then any address.
                    if ($urandom_range(0, 7) == 0)
                        addr = $urandom();
                    else
                        addr = ($urandom_range(0, limit + 2) << PAGE_SHIFT)
                             | $urandom_range(0, PAGE_BYTES - 1);
                    send_request(KIND_FREE, addr, 1'b0, '0);
                end
            end
        end

        // Let the last results arrive, then keep watching for stray beats before the verdict.
        req_bus.valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
